// ===== design/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

   localparam int NUM_PAGES_DEFAULT = 65536;
   localparam int WORD_BITS_DEFAULT = 64;

   localparam int CMD_W   = 1;
   localparam int INDEX_W = 16;
   localparam int COUNT_W = 17;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   // page arithmetic width: start plus step or count stays below 2**18
   localparam int PAGE_W = 18;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_TOTAL  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_START = 1'b1;

   localparam logic [COUNT_W-1:0] PAGE_TOTAL_RESET   = 17'd65536;
   localparam logic [INDEX_W-1:0] SEARCH_START_RESET = 16'd8192;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_LOOP,
      ST_READ,
      ST_TEST,
      ST_SKIP,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_RESP
   } state_type;

endpackage

// ===== design/bpa_if.sv =====
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::CMD_W-1:0]    command;
   logic [bpa_pkg::INDEX_W-1:0]  page_index;
   logic [bpa_pkg::COUNT_W-1:0]  page_count;
   logic [bpa_pkg::COUNT_W-1:0]  step;
   logic [bpa_pkg::COUNT_W-1:0]  upper_limit;

   modport source (output valid, command, page_index, page_count, step, upper_limit,
                   input ready);
   modport sink (input valid, command, page_index, page_count, step, upper_limit,
                 output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::INDEX_W-1:0]   run_start;
   logic [bpa_pkg::COUNT_W-1:0]   pages_free;

   modport source (output valid, status, run_start, pages_free, input ready);
   modport sink (input valid, status, run_start, pages_free, output ready);
endinterface

// ===== design/bitmap_page_allocator_top.sv =====
// Bitmap first-fit page allocator: top level with bitmap memory and sequencer.
//
// One request is in flight at a time. After reset a fill pass writes every bitmap
// word to all ones while req.ready stays low. A free reads and rewrites the
// bitmap word of each page of its run in turn. An allocation tests one page at
// a time (one bitmap read port with a registered read), advances the candidate
// start by one step per cycle past a used page, and then marks the run page by
// page, so its latency grows with the run length and the number of used pages
// it meets; the response register holds the result until it is taken.
module bitmap_page_allocator_top #(
   parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEFAULT,
   parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   bpa_req_if.sink                          req,
   bpa_rsp_if.source                        rsp,
   input  logic                             csr_write_enable,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int PW = bpa_pkg::PAGE_W;
   localparam int WORD_COUNT = NUM_PAGES / WORD_BITS;
   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW = $clog2(WORD_BITS);
   localparam int CNTW = $clog2(NUM_PAGES + 1);
   localparam int FW = ((CNTW > bpa_pkg::COUNT_W) ? CNTW : bpa_pkg::COUNT_W) + 1;
   localparam int NP_CAP = (NUM_PAGES > 131071) ? 131071 : NUM_PAGES;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

   bpa_pkg::state_type state_ff, state_in;

   logic [bpa_pkg::COUNT_W-1:0]  page_total_ff;
   logic [bpa_pkg::INDEX_W-1:0]  search_start_ff;
   logic [CNTW-1:0]              free_ff, free_in;

   logic [bpa_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PW-1:0]                count_ff, count_in;
   logic [PW-1:0]                step_ff, step_in;
   logic [PW-1:0]                bound_ff, bound_in;
   logic [PW-1:0]                idx_ff, idx_in;
   logic [PW-1:0]                page_ff, page_in;
   logic [PW-1:0]                last_ff, last_in;
   logic                         set_ff, set_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [bpa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [bpa_pkg::INDEX_W-1:0]  start_ff, start_in;

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_re;
   logic                 mem_we;
   logic [AW-1:0]        mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [PW-1:0]        total_eff;
   logic [PW-1:0]        req_bound;
   logic [PW-1:0]        req_count;
   logic [PW-1:0]        idx_next;
   logic [WORD_BITS-1:0] bit_mask;
   logic                 page_used;
   logic [FW-1:0]        free_ext;
   logic [FW-1:0]        cnt_ext;
   logic [FW-1:0]        free_sum;
   logic                 accept;

   assign accept = req.valid && req.ready;
   assign total_eff = (PW'(page_total_ff) > PW'(NP_CAP)) ? PW'(NP_CAP) : PW'(page_total_ff);
   assign req_count = PW'(req.page_count);
   assign req_bound = (req.upper_limit != '0 && PW'(req.upper_limit) < total_eff)
                      ? PW'(req.upper_limit) : total_eff;
   assign idx_next  = idx_ff + step_ff;
   assign bit_mask  = WORD_BITS'(1) << page_ff[BW-1:0];
   assign page_used = rdata_ff[page_ff[BW-1:0]];
   assign free_ext  = FW'(free_ff);
   assign cnt_ext   = FW'(count_ff);
   assign free_sum  = free_ext + cnt_ext;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_total_ff   <= bpa_pkg::PAGE_TOTAL_RESET;
         search_start_ff <= bpa_pkg::SEARCH_START_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bpa_pkg::CSR_PAGE_TOTAL:   page_total_ff <= csr_write_data;
            bpa_pkg::CSR_SEARCH_START: search_start_ff <= csr_write_data[bpa_pkg::INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      free_in   = free_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      bound_in  = bound_ff;
      idx_in    = idx_ff;
      page_in   = page_ff;
      last_in   = last_ff;
      set_in    = set_ff;
      clr_in    = clr_ff;
      status_in = status_ff;
      start_in  = start_ff;
      unique case (state_ff)
         bpa_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         bpa_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req.command;
               count_in = req_count;
               step_in  = (req.step == '0) ? PW'(1) : PW'(req.step);
               bound_in = req_bound;
               idx_in   = PW'(search_start_ff);
               page_in  = PW'(req.page_index);
               last_in  = PW'(req.page_index) + req_count - PW'(1);
               start_in = '0;
               state_in = bpa_pkg::ST_CHECK;
            end
         end
         bpa_pkg::ST_CHECK: begin
            if (cmd_ff == bpa_pkg::CMD_ALLOC) begin
               if (count_ff == '0 || count_ff > bound_ff) begin
                  status_in = bpa_pkg::STATUS_REJECT;
                  state_in  = bpa_pkg::ST_RESP;
               end else begin
                  status_in = bpa_pkg::STATUS_NO_SPACE;
                  state_in  = bpa_pkg::ST_LOOP;
               end
            end else begin
               if (count_ff == '0 || last_ff >= total_eff) begin
                  status_in = bpa_pkg::STATUS_REJECT;
                  state_in  = bpa_pkg::ST_RESP;
               end else begin
                  set_in   = 1'b0;
                  state_in = bpa_pkg::ST_UPD_READ;
               end
            end
         end
         bpa_pkg::ST_LOOP: begin
            if (idx_ff < bound_ff && idx_ff + count_ff <= bound_ff) begin
               page_in  = idx_ff;
               last_in  = idx_ff + count_ff - PW'(1);
               state_in = bpa_pkg::ST_READ;
            end else begin
               state_in = bpa_pkg::ST_RESP;
            end
         end
         bpa_pkg::ST_READ: begin
            state_in = bpa_pkg::ST_TEST;
         end
         bpa_pkg::ST_TEST: begin
            priority if (page_used) begin
               state_in = bpa_pkg::ST_SKIP;
            end else if (page_ff == last_ff) begin
               page_in  = idx_ff;
               set_in   = 1'b1;
               state_in = bpa_pkg::ST_UPD_READ;
            end else begin
               page_in  = page_ff + PW'(1);
               state_in = bpa_pkg::ST_READ;
            end
         end
         bpa_pkg::ST_SKIP: begin
            // advance the start until it passes the used page
            idx_in = idx_next;
            if (idx_next > page_ff) begin
               state_in = bpa_pkg::ST_LOOP;
            end
         end
         bpa_pkg::ST_UPD_READ: begin
            state_in = bpa_pkg::ST_UPD_WRITE;
         end
         bpa_pkg::ST_UPD_WRITE: begin
            if (page_ff == last_ff) begin
               status_in = bpa_pkg::STATUS_DONE;
               state_in  = bpa_pkg::ST_RESP;
               if (set_ff) begin
                  start_in = idx_ff[bpa_pkg::INDEX_W-1:0];
                  free_in  = (free_ext > cnt_ext) ? CNTW'(free_ext - cnt_ext) : '0;
               end else begin
                  free_in = (free_sum > FW'(NUM_PAGES)) ? CNTW'(NUM_PAGES) : CNTW'(free_sum);
               end
            end else begin
               page_in  = page_ff + PW'(1);
               state_in = bpa_pkg::ST_UPD_READ;
            end
         end
         bpa_pkg::ST_RESP: begin
            if (rsp.ready) begin
               state_in = bpa_pkg::ST_IDLE;
            end
         end
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = AW'(page_ff >> BW);
      mem_wdata = set_ff ? (rdata_ff | bit_mask) : (rdata_ff & ~bit_mask);
      unique case (state_ff)
         bpa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '1;
         end
         bpa_pkg::ST_IDLE:      req.ready = 1'b1;
         bpa_pkg::ST_READ:      mem_re = 1'b1;
         bpa_pkg::ST_UPD_READ:  mem_re = 1'b1;
         bpa_pkg::ST_UPD_WRITE: mem_we = 1'b1;
         bpa_pkg::ST_RESP:      rsp.valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp.status     = status_ff;
   assign rsp.run_start  = start_ff;
   assign rsp.pages_free = bpa_pkg::COUNT_W'(free_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_CLEAR;
         free_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      count_ff  <= count_in;
      step_ff   <= step_in;
      bound_ff  <= bound_in;
      idx_ff    <= idx_in;
      page_ff   <= page_in;
      last_ff   <= last_in;
      set_ff    <= set_in;
      status_ff <= status_in;
      start_ff  <= start_in;
   end

   a_ready_excl_valid: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid)
      else $error("request ready while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("ready stayed high after a request transfer");

   a_counter_cap: assert property (@(posedge clock) disable iff (reset)
      FW'(free_ff) <= FW'(NUM_PAGES))
      else $error("free counter above page count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == bpa_pkg::STATUS_DONE ||
                     rsp.status == bpa_pkg::STATUS_NO_SPACE ||
                     rsp.status == bpa_pkg::STATUS_REJECT))
      else $error("invalid response status");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != bpa_pkg::STATUS_DONE) |-> rsp.run_start == '0)
      else $error("run start set on a failed request");

endmodule
